[rtl/uart_line_assembler_unit_defines.svh]
// assertion macros for the line assembler rtl
`ifndef UART_LINE_ASSEMBLER_UNIT_DEFINES_SVH
`define UART_LINE_ASSEMBLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ULA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ula assertion failed");
`define ULA_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ula reset assertion failed");
`else
`define ULA_ASSERT(name, prop)
`define ULA_ASSERT_RST(name, prop)
`endif

`endif

[rtl/ula_pkg.sv]
package ula_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LEN_W       = 7;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam cmd_t CMD_RX_BYTE   = 2'd0;
  localparam cmd_t CMD_READ_LINE = 2'd1;
  localparam cmd_t CMD_STATUS    = 2'd2;

  localparam char_t CH_CR  = 8'h0D;
  localparam char_t CH_LF  = 8'h0A;
  localparam char_t CH_NUL = 8'h00;

endpackage

[rtl/ula_if.sv]
interface ula_in_if import ula_pkg::*; ();
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  char_t rx_byte;
  len_t  max_len;

  modport source (output valid, output cmd, output rx_byte, output max_len, input ready);
  modport sink (input valid, input cmd, input rx_byte, input max_len, output ready);
endinterface

interface ula_out_if import ula_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  last;
  logic  line_ready;
  logic  dropped;

  modport source (output valid, output out_char, output last, output line_ready,
                  output dropped, input ready);
  modport sink (input valid, input out_char, input last, input line_ready,
                input dropped, output ready);
endinterface

[rtl/uart_line_assembler_unit.sv]
// Line assembler for received UART characters. A line read of n characters starts with a
// store read and then gives one result per cycle while the output register is free, n
// characters plus the terminator, paced by the single read port of the 64-entry line store
// and its registered read data. Results leave through an output register, and a new request
// is taken once the current one is done and that register is free. The store needs no clearing
// pass after reset: per-entry valid bits make untouched entries read as zero.
`include "uart_line_assembler_unit_defines.svh"

module uart_line_assembler_unit import ula_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ula_in_if.sink    req_i,
  ula_out_if.source rsp_o
);

  typedef enum logic {S_IDLE, S_WALK} state_e;

  state_e state_q, state_d;

  char_t                  mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_q;
  logic                   mem_we;
  addr_t                  mem_waddr;
  char_t                  mem_wdata;
  logic                   valid_clr0;
  logic                   rd_en;
  addr_t                  rd_addr;
  char_t                  rd_data_q;
  logic                   rd_hit_q;
  char_t                  rd_char;

  addr_t fill_q, fill_d;
  logic  ovf_q, ovf_d;
  logic  ready_q, ready_d;
  logic  dropped_q, dropped_d;
  addr_t idx_q, idx_d;
  len_t  maxlen_q, maxlen_d;
  logic  rdy_snap_q, rdy_snap_d;
  logic  drp_snap_q, drp_snap_d;

  logic  out_valid_q, out_valid_d;
  char_t out_char_q, out_char_d;
  logic  out_last_q, out_last_d;
  logic  out_rdy_q, out_rdy_d;
  logic  out_drp_q, out_drp_d;

  logic out_free;
  logic accept;
  logic is_eol;
  logic walk_more;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && out_free;
  assign accept      = req_i.valid && req_i.ready;
  assign is_eol      = (req_i.rx_byte == CH_CR) || (req_i.rx_byte == CH_LF);
  assign rd_char     = rd_hit_q ? rd_data_q : CH_NUL;

  // walk bound: below max_len minus one, below the store size minus one, and not at a zero byte
  assign walk_more = ((LEN_W'(idx_q) + LEN_W'(1)) < maxlen_q) &&
                     (idx_q != ADDR_W'(STORE_DEPTH - 1)) &&
                     (rd_char != CH_NUL);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_char   = out_char_q;
  assign rsp_o.last       = out_last_q;
  assign rsp_o.line_ready = out_rdy_q;
  assign rsp_o.dropped    = out_drp_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    ready_d     = ready_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    maxlen_d    = maxlen_q;
    rdy_snap_d  = rdy_snap_q;
    drp_snap_d  = drp_snap_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_rdy_d   = out_rdy_q;
    out_drp_d   = out_drp_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_q;
    mem_wdata   = req_i.rx_byte;
    valid_clr0  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_RX_BYTE: begin
              if (is_eol) begin
                if (ovf_q) begin
                  // drop the overflowed line
                  ovf_d      = 1'b0;
                  fill_d     = '0;
                  valid_clr0 = 1'b1;
                  ready_d    = 1'b0;
                  dropped_d  = 1'b1;
                end else begin
                  if ((fill_q != '0) && !ready_q) begin
                    mem_we    = 1'b1;
                    mem_wdata = CH_NUL;
                    ready_d   = 1'b1;
                  end
                  fill_d = '0;
                end
              end else if (!ready_q) begin
                if (fill_q != ADDR_W'(STORE_DEPTH - 1)) begin
                  mem_we = 1'b1;
                  fill_d = fill_q + ADDR_W'(1);
                end else begin
                  fill_d = '0;
                  ovf_d  = 1'b1;
                end
              end
            end
            CMD_READ_LINE: begin
              if (req_i.max_len != '0) begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_d      = '0;
                maxlen_d   = req_i.max_len;
                rdy_snap_d = ready_q;
                drp_snap_d = dropped_q;
                state_d    = S_WALK;
              end
            end
            CMD_STATUS: begin
              out_valid_d = 1'b1;
              out_char_d  = CH_NUL;
              out_last_d  = 1'b1;
              out_rdy_d   = ready_q;
              out_drp_d   = dropped_q;
              dropped_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rdy_d   = rdy_snap_q;
          out_drp_d   = drp_snap_q;
          if (walk_more) begin
            out_char_d = rd_char;
            out_last_d = 1'b0;
            rd_en      = 1'b1;
            rd_addr    = idx_q + ADDR_W'(1);
            idx_d      = idx_q + ADDR_W'(1);
          end else begin
            out_char_d = CH_NUL;
            out_last_d = 1'b1;
            ready_d    = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      ready_q     <= 1'b0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      maxlen_q    <= '0;
      rdy_snap_q  <= 1'b0;
      drp_snap_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_rdy_q   <= 1'b0;
      out_drp_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      ready_q     <= ready_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      maxlen_q    <= maxlen_d;
      rdy_snap_q  <= rdy_snap_d;
      drp_snap_q  <= drp_snap_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_rdy_q   <= out_rdy_d;
      out_drp_q   <= out_drp_d;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[mem_waddr] <= 1'b1;
    end else if (valid_clr0) begin
      valid_q[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // read data holds while the walk waits on the output register
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_hit_q  <= valid_q[rd_addr];
    end
  end

  `ULA_ASSERT(a_no_write_in_walk, (state_q == S_WALK) |-> !mem_we && !valid_clr0)
  `ULA_ASSERT(a_walk_in_bound, (state_q == S_WALK) |-> (LEN_W'(idx_q) < maxlen_q))
  `ULA_ASSERT(a_walk_end_clears_ready, (state_q == S_WALK && state_d == S_IDLE) |=> !ready_q)
  `ULA_ASSERT_RST(a_reset_idle, !rst_ni |-> (state_q == S_IDLE) && !out_valid_q)

endmodule

[verif/uart_line_assembler_unit_test.sv]
`timescale 1ns / 1ps

module uart_line_assembler_unit_test;
  import ula_pkg::*;

  localparam cmd_t CMD_UNUSED  = 2'd3;
  localparam int   CYCLE_LIMIT = 500000;
  localparam int   HOLD_CYCLES = 300;
  localparam int   TOTAL_ITEMS = 280;
  localparam int   SETTLE      = 20;
  localparam int   N_ROWS      = 27;

  typedef struct packed {
    char_t ch;
    logic  last;
    logic  line_ready;
    logic  dropped;
  } char_rec_t;

  typedef struct packed {
    cmd_t      cmd;
    char_t     rx;
    len_t      len;
    logic [7:0] reps;
    logic      typed;
    char_rec_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ula_in_if  req_if ();
  ula_out_if rsp_if ();

  uart_line_assembler_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // shadow of the line assembler
  char_t line_mem [STORE_DEPTH];
  int    fill_cnt;
  bit    ovf_seen;
  bit    line_rdy;
  bit    drop_seen;

  char_rec_t expected_chars [$];

  int err_cnt;
  int cyc_cnt;
  int items_sent;
  bit no_gaps;
  bit hold_start;
  bit rsp_hold_on;

  // directed rows; typed expectations only for single-result rows
  stim_row_t dir_rows [N_ROWS] = '{
    '{CMD_READ_LINE, 8'h00, 7'd5,  8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b0}},
    '{CMD_STATUS,    8'h00, 7'd0,  8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b0}},
    '{CMD_RX_BYTE,   8'h41, 7'd64, 8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   8'hFF, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   8'h01, 7'd1,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   CH_CR, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_STATUS,    8'hFF, 7'd64, 8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b1, 1'b0}},
    // ignored while a line waits
    '{CMD_RX_BYTE,   8'h42, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   CH_LF, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_READ_LINE, 8'h00, 7'd64, 8'd1,  1'b0, '0},
    '{CMD_READ_LINE, 8'hFF, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_READ_LINE, 8'h00, 7'd1,  8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b0}},
    '{CMD_UNUSED,    8'hAA, 7'd64, 8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   CH_LF, 7'd0,  8'd1,  1'b0, '0},
    // stale walk with nothing ready
    '{CMD_READ_LINE, 8'h00, 7'd2,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   8'h80, 7'd0,  8'd63, 1'b0, '0},
    '{CMD_RX_BYTE,   CH_CR, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_READ_LINE, 8'h00, 7'd64, 8'd1,  1'b0, '0},
    // one past full overflows, the line end then drops it
    '{CMD_RX_BYTE,   8'h7F, 7'd0,  8'd65, 1'b0, '0},
    '{CMD_RX_BYTE,   CH_LF, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_STATUS,    8'h00, 7'd0,  8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b1}},
    '{CMD_STATUS,    8'h00, 7'd0,  8'd1,  1'b1, '{CH_NUL, 1'b1, 1'b0, 1'b0}},
    '{CMD_READ_LINE, 8'h00, 7'd64, 8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   8'h00, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   8'h33, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_RX_BYTE,   CH_CR, 7'd0,  8'd1,  1'b0, '0},
    '{CMD_READ_LINE, 8'h00, 7'd10, 8'd1,  1'b0, '0}
  };

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cyc_cnt);
    err_cnt++;
  endtask

  task automatic push_char(char_t c, bit lst, bit keep);
    char_rec_t r;
    r.ch         = c;
    r.last       = lst;
    r.line_ready = line_rdy;
    r.dropped    = drop_seen;
    if (keep) expected_chars.push_back(r);
  endtask

  task automatic take_rx_char(char_t b);
    if (b == CH_CR || b == CH_LF) begin
      if (ovf_seen) begin
        ovf_seen    = 0;
        fill_cnt    = 0;
        line_mem[0] = CH_NUL;
        line_rdy    = 0;
        drop_seen   = 1;
      end else begin
        if (fill_cnt > 0 && !line_rdy) begin
          line_mem[fill_cnt] = CH_NUL;
          line_rdy = 1;
        end
        fill_cnt = 0;
      end
    end else if (!line_rdy) begin
      if (fill_cnt < STORE_DEPTH - 1) begin
        line_mem[fill_cnt] = b;
        fill_cnt++;
      end else begin
        fill_cnt = 0;
        ovf_seen = 1;
      end
    end
  endtask

  // advance the shadow by one request; keep=0 drops its results
  task automatic line_model_step(cmd_t c, char_t b, len_t n, bit keep);
    int i;
    i = 0;
    case (c)
      CMD_RX_BYTE: take_rx_char(b);
      CMD_READ_LINE: begin
        if (n != 0) begin
          while (i + 1 < int'(n) && i < STORE_DEPTH - 1 && line_mem[i] != CH_NUL) begin
            push_char(line_mem[i], 1'b0, keep);
            i++;
          end
          push_char(CH_NUL, 1'b1, keep);
          line_rdy = 0;
        end
      end
      CMD_STATUS: begin
        push_char(CH_NUL, 1'b1, keep);
        drop_seen = 0;
      end
      default: ;
    endcase
  endtask

  // called at a falling edge, returns at the next falling edge after acceptance
  task automatic send_item(cmd_t c, char_t b, len_t n, bit typed, char_rec_t want);
    if (!no_gaps && $urandom_range(99) < 28) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.cmd     <= c;
    req_if.rx_byte <= b;
    req_if.max_len <= n;
    do @(posedge clk); while (!req_if.ready);
    line_model_step(c, b, n, !typed);
    if (typed) expected_chars.push_back(want);
    if (c != CMD_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(cmd_t c, char_t b, len_t n);
    send_item(c, b, n, 1'b0, '0);
  endtask

  task automatic wait_all_done();
    req_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic char_t text_char();
    char_t b;
    if ($urandom_range(99) < 5) return char_t'($urandom_range(0, 9));
    do b = char_t'($urandom_range(1, 255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic len_t any_len();
    return len_t'($urandom_range(0, 64));
  endfunction

  task automatic send_line();
    int r;
    int n_chars;
    r = $urandom_range(99);
    if (r < 85) n_chars = $urandom_range(1, 10);
    else if (r < 95) n_chars = $urandom_range(11, 40);
    else n_chars = $urandom_range(60, 66);
    repeat (n_chars) send_plain(CMD_RX_BYTE, text_char(), any_len());
    send_plain(CMD_RX_BYTE, $urandom_range(1) ? CH_CR : CH_LF, any_len());
    if ($urandom_range(3) == 0) send_plain(CMD_STATUS, char_t'($urandom), any_len());
    send_plain(CMD_READ_LINE, char_t'($urandom),
               ($urandom_range(99) < 60) ? len_t'(64) : any_len());
    // occasional second read walks the stale store
    if ($urandom_range(4) == 0) send_plain(CMD_READ_LINE, char_t'($urandom), any_len());
  endtask

  task automatic send_noise();
    int r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(9);
      if (r < 6) send_plain(CMD_RX_BYTE, char_t'($urandom), any_len());
      else if (r < 8) send_plain(CMD_READ_LINE, char_t'($urandom), any_len());
      else if (r < 9) send_plain(CMD_STATUS, char_t'($urandom), any_len());
      else send_plain(CMD_UNUSED, char_t'($urandom), any_len());
    end
  endtask

  task automatic check_result();
    char_rec_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("result without request", rsp_if.out_char, 8'h00);
      return;
    end
    want = expected_chars.pop_front();
    if (rsp_if.out_char !== want.ch)
      report_mismatch("out_char", rsp_if.out_char, want.ch);
    if (rsp_if.last !== want.last)
      report_mismatch("last", 8'(rsp_if.last), 8'(want.last));
    if (rsp_if.line_ready !== want.line_ready)
      report_mismatch("line_ready", 8'(rsp_if.line_ready), 8'(want.line_ready));
    if (rsp_if.dropped !== want.dropped)
      report_mismatch("dropped", 8'(rsp_if.dropped), 8'(want.dropped));
  endtask

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) check_result();
  end

  // receiver side
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rsp_hold_on) rsp_if.ready <= 1'b0;
      else if (no_gaps) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(99) >= 28);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    rsp_hold_on = 1'b0;
    wait (hold_start);
    @(posedge clk);
    rsp_hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold_on = 1'b0;
  end

  initial begin : stim
    bit hold_done;
    bit pause_done;
    clk            = 1'b0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.cmd     = CMD_RX_BYTE;
    req_if.rx_byte = '0;
    req_if.max_len = '0;
    err_cnt        = 0;
    items_sent     = 0;
    no_gaps        = 1'b0;
    hold_start     = 1'b0;
    hold_done      = 1'b0;
    pause_done     = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = CH_NUL;
    fill_cnt  = 0;
    ovf_seen  = 0;
    line_rdy  = 0;
    drop_seen = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps)
        send_item(dir_rows[r].cmd, dir_rows[r].rx, dir_rows[r].len,
                  dir_rows[r].typed, dir_rows[r].want);
    end

    while (items_sent < TOTAL_ITEMS) begin
      no_gaps = (items_sent >= 190 && items_sent < 240);
      if (!hold_done && items_sent >= 170) begin
        hold_start = 1'b1;
        hold_done  = 1'b1;
      end
      if (!pause_done && items_sent >= 250) begin
        wait_all_done();
        pause_done = 1'b1;
      end
      if ($urandom_range(99) < 70) send_line();
      else send_noise();
    end
    no_gaps = 1'b0;

    wait_all_done();
    if (expected_chars.size() != 0)
      report_mismatch("results still expected", 8'(expected_chars.size()), 8'h00);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ula_pkg.sv
rtl/ula_if.sv
rtl/uart_line_assembler_unit.sv
verif/uart_line_assembler_unit_test.sv
